// ----- hdl/sensor_frame_crc8_decode_macros.svh -----
// Assertion macros shared by the sensor frame decoder RTL.
// Standalone header; expects clk and rst_n in the including module's scope.
`ifndef SENSOR_FRAME_CRC8_DECODE_MACROS_SVH
`define SENSOR_FRAME_CRC8_DECODE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define SFCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SFCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SFCD_ASSERT_NOW(lbl, ante, cons, msg)
`define SFCD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- hdl/sfcd_pkg.sv -----
// Types, constants and the CRC-8 byte step for the sensor frame decoder.
// No dependencies.
`default_nettype none

package sfcd_pkg;

    localparam logic [7:0] CRC_POLY    = 8'h31;
    localparam logic [7:0] CRC_INIT    = 8'hFF;
    localparam int unsigned RAW_W      = 20;
    localparam logic [6:0] HUM_SCALE   = 7'd100;
    localparam logic [7:0] TEMP_SCALE  = 8'd200;
    localparam logic [8:0] TEMP_OFFSET = 9'd50;

    // Byte positions within a frame.
    localparam logic [2:0] POS_STATUS  = 3'd0;
    localparam logic [2:0] POS_HUM_HI  = 3'd1;
    localparam logic [2:0] POS_HUM_MID = 3'd2;
    localparam logic [2:0] POS_SPLIT   = 3'd3;
    localparam logic [2:0] POS_TMP_MID = 3'd4;
    localparam logic [2:0] POS_TMP_LO  = 3'd5;
    localparam logic [2:0] POS_CRC     = 3'd6;

    localparam logic [6:0] HUM_MAX     = 7'd99;

    // Result payload; the last member sits in the lowest bits.
    typedef struct packed {
        logic [7:0]       status_value;
        logic [RAW_W-1:0] temperature_raw;
        logic [RAW_W-1:0] humidity_raw;
        logic signed [8:0] temperature_celsius;
        logic [6:0]       humidity_percent;
    } result_t;

    // One CRC-8 byte step, MSB first, no reflection.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sensor_frame_crc8_decode.sv -----
// Top level of the sensor measurement frame decoder with CRC-8 check.
// Depends on sfcd_pkg and sensor_frame_crc8_decode_macros.svh.
//
// Usage:
//   The slave channel carries one frame byte per transfer: s_tdata holds the
//   byte and s_tuser marks the byte as byte 0 of a new frame, which drops any
//   partial frame. Without that mark the byte index wraps after seven bytes.
//   The master channel carries one result per complete frame, issued on the
//   transfer of byte 6 (the CRC byte): scaled humidity and temperature, both
//   raw values, the status byte, and in m_tuser a flag that the CRC matched.
//   Each byte is held in an input register and the frame state is updated as
//   it leaves it; m_tvalid is registered and rises as the result register is
//   loaded when the CRC byte leaves the input register. One byte per cycle is
//   sustained while no result waits on a stalled receiver; the CRC step feeds
//   the frame state and the two constant multiplies feed the result register.
//   When the receiver stalls with a result pending, bytes that produce no
//   result still drain into the frame state; only the next CRC byte waits,
//   and s_tready drops once it reaches the input register.
//   Reset clears the byte index, the status byte, the accumulators and both
//   valid flags and sets the CRC to 0xFF; no result is pending after reset.
`default_nettype none

`include "sensor_frame_crc8_decode_macros.svh"

module sensor_frame_crc8_decode
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] frame_start

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [6:0] humidity_percent, [15:7] temperature_celsius, [35:16] humidity_raw,
    // [55:36] temperature_raw, [63:56] status_value
    output logic [63:0]      m_tdata,
    output logic             m_tuser    // [0] crc_ok
);

    localparam int unsigned RAW_W = sfcd_pkg::RAW_W;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Frame state.
    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       status_reg, status_next;
    logic [RAW_W-1:0] hum_acc_reg, hum_acc_next;
    logic [RAW_W-1:0] temp_acc_reg, temp_acc_next;

    // Result register.
    logic               m_valid_reg;
    sfcd_pkg::result_t  out_reg, out_next;
    logic               crc_ok_reg, crc_ok_next;

    logic [2:0] pos_eff;
    logic       is_last;
    logic       out_free;
    logic       advance;
    logic       frame_done;
    logic [7:0] crc_step;

    logic [RAW_W+6:0] hum_prod;
    logic [RAW_W+7:0] temp_prod;

    assign pos_eff  = (in_start_reg || pos_reg > sfcd_pkg::POS_CRC) ? sfcd_pkg::POS_STATUS
                                                                     : pos_reg;
    assign is_last  = (pos_eff == sfcd_pkg::POS_CRC);
    assign out_free = !m_valid_reg || m_tready;
    // The held byte moves on unless it would overwrite a result still waiting.
    assign advance  = in_valid_reg && (!is_last || out_free);
    assign s_tready = !in_valid_reg || advance;
    // The CRC byte leaves the input register and its result is loaded.
    assign frame_done = advance && is_last;

    assign crc_step = sfcd_pkg::crc8_step(
        (pos_eff == sfcd_pkg::POS_STATUS) ? sfcd_pkg::CRC_INIT : crc_reg, in_byte_reg);

    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        status_next   = status_reg;
        hum_acc_next  = hum_acc_reg;
        temp_acc_next = temp_acc_reg;
        if (advance)
        begin
            pos_next = is_last ? sfcd_pkg::POS_STATUS : 3'(pos_eff + 3'd1);
            unique case (pos_eff)
                sfcd_pkg::POS_STATUS:
                begin
                    crc_next      = crc_step;
                    status_next   = in_byte_reg;
                    hum_acc_next  = '0;
                    temp_acc_next = '0;
                end
                sfcd_pkg::POS_HUM_HI:
                begin
                    crc_next     = crc_step;
                    hum_acc_next = {in_byte_reg, 12'b0};
                end
                sfcd_pkg::POS_HUM_MID:
                begin
                    crc_next     = crc_step;
                    hum_acc_next = hum_acc_reg | {8'b0, in_byte_reg, 4'b0};
                end
                sfcd_pkg::POS_SPLIT:
                begin
                    crc_next      = crc_step;
                    hum_acc_next  = hum_acc_reg | {16'b0, in_byte_reg[7:4]};
                    temp_acc_next = {in_byte_reg[3:0], 16'b0};
                end
                sfcd_pkg::POS_TMP_MID:
                begin
                    crc_next      = crc_step;
                    temp_acc_next = temp_acc_reg | {4'b0, in_byte_reg, 8'b0};
                end
                sfcd_pkg::POS_TMP_LO:
                begin
                    crc_next      = crc_step;
                    temp_acc_next = temp_acc_reg | {12'b0, in_byte_reg};
                end
                default:
                begin
                    // CRC byte: the frame state is left for the next status byte.
                end
            endcase
        end
    end

    // Constant scaling of the raw values; the shift by 20 keeps the top bits.
    assign hum_prod  = (RAW_W+7)'(hum_acc_reg) * (RAW_W+7)'(sfcd_pkg::HUM_SCALE);
    assign temp_prod = (RAW_W+8)'(temp_acc_reg) * (RAW_W+8)'(sfcd_pkg::TEMP_SCALE);

    always_comb
    begin
        out_next.humidity_percent    = hum_prod[RAW_W+6:RAW_W];
        out_next.temperature_celsius = signed'({1'b0, temp_prod[RAW_W+7:RAW_W]}
                                               - sfcd_pkg::TEMP_OFFSET);
        out_next.humidity_raw        = hum_acc_reg;
        out_next.temperature_raw     = temp_acc_reg;
        out_next.status_value        = status_reg;
        crc_ok_next                  = (crc_reg == in_byte_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= sfcd_pkg::POS_STATUS;
            crc_reg      <= sfcd_pkg::CRC_INIT;
            status_reg   <= '0;
            hum_acc_reg  <= '0;
            temp_acc_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            pos_reg      <= pos_next;
            crc_reg      <= crc_next;
            status_reg   <= status_next;
            hum_acc_reg  <= hum_acc_next;
            temp_acc_reg <= temp_acc_next;
            if (out_free)
            begin
                m_valid_reg <= frame_done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (frame_done)
        begin
            out_reg    <= out_next;
            crc_ok_reg <= crc_ok_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = crc_ok_reg;

    `SFCD_ASSERT_NOW(a_pos_range, 1'b1, pos_reg <= sfcd_pkg::POS_CRC, "byte index out of range")
    `SFCD_ASSERT_NEXT(a_last_gives_result, frame_done, m_valid_reg, "CRC byte lost its result")
    `SFCD_ASSERT_NEXT(a_wrap, frame_done, pos_reg == sfcd_pkg::POS_STATUS, "index did not wrap")
    `SFCD_ASSERT_NOW(a_hum_max, m_tvalid, m_tdata[6:0] <= sfcd_pkg::HUM_MAX, "humidity above 99")

endmodule

`default_nettype wire
